/* sv/krt_pkg.sv */
package krt_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int KEY_W        = 16;
    localparam int SCORE_W      = 10;
    localparam int REC_W        = KEY_W + SCORE_W;

    typedef enum logic [2:0] {
        MODE_APPEND = 3'd0,
        MODE_DELETE = 3'd1,
        MODE_SEARCH = 3'd2,
        MODE_SORT   = 3'd3,
        MODE_DUMP   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_WAIT,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_SORT_RD,
        S_SORT_LOAD,
        S_SORT_CMP,
        S_SORT_PUT,
        S_DUMP_RD,
        S_DUMP_OUT,
        S_OUT
    } fsm_t;

endpackage

/* sv/krt_store.sv */
module krt_store
    import krt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [REC_W-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [REC_W-1:0] rd_data
);

    logic [REC_W-1:0] mem [CAPACITY];
    logic [REC_W-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/keyed_record_table.sv */
// keyed record table: up to CAPACITY (key, score) records in one record memory
// append, empty-table and unused-mode items go straight to the result state
// search/delete: read, compare per scanned entry; delete adds read, write per
// shifted entry; dump: one record per cycle while m_tready is high; insertion
// sort: compare per step, read and load per record; one item in flight at a time
// synchronous active-low reset empties the table; memory contents are not cleared
module keyed_record_table
    import krt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // mode[2:0], key[18:3], score[28:19], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status[1:0], position[7:2], found_key[23:8],
                                   // found_score[33:24], entries[39:34]
    output logic        m_tlast
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    fsm_t state_reg, state_next;
    logic [CW-1:0] occ_reg, occ_next;
    logic [2:0] mode_reg, mode_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [CW-1:0] i_reg, i_next;   // scan/outer index
    logic [CW-1:0] j_reg, j_next;   // insertion index
    logic [REC_W-1:0] hold_reg, hold_next; // record being inserted
    logic [1:0] o_st_reg, o_st_next;
    logic [CW-1:0] o_pos_reg, o_pos_next;
    logic [KEY_W-1:0] o_key_reg, o_key_next;
    logic [SCORE_W-1:0] o_sc_reg, o_sc_next;
    logic o_last_reg, o_last_next;

    logic wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [REC_W-1:0] wr_data, rd_data;
    logic [KEY_W-1:0] rd_key;
    logic [SCORE_W-1:0] rd_sc;

    assign rd_key = rd_data[REC_W-1:SCORE_W];
    assign rd_sc  = rd_data[SCORE_W-1:0];

    krt_store #(.CAPACITY(CAPACITY)) u_store (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
        end else begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        mode_reg   <= mode_next;
        key_reg    <= key_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        hold_reg   <= hold_next;
        o_st_reg   <= o_st_next;
        o_pos_reg  <= o_pos_next;
        o_key_reg  <= o_key_next;
        o_sc_reg   <= o_sc_next;
        o_last_reg <= o_last_next;
    end

    // sequencer
    always_comb begin
        state_next  = state_reg;
        occ_next    = occ_reg;
        mode_next   = mode_reg;
        key_next    = key_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        hold_next   = hold_reg;
        o_st_next   = o_st_reg;
        o_pos_next  = o_pos_reg;
        o_key_next  = o_key_reg;
        o_sc_next   = o_sc_reg;
        o_last_next = o_last_reg;
        wr_en       = 1'b0;
        wr_addr     = i_reg[AW-1:0];
        wr_data     = rd_data;
        rd_addr     = i_reg[AW-1:0];
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    mode_next   = s_tdata[2:0];
                    key_next    = s_tdata[18:3];
                    i_next      = '0;
                    o_last_next = 1'b1;
                    o_st_next   = ST_OK;
                    o_pos_next  = '0;
                    o_key_next  = '0;
                    o_sc_next   = '0;
                    rd_addr     = '0;
                    case (s_tdata[2:0])
                        MODE_APPEND: begin
                            o_key_next = s_tdata[18:3];
                            o_sc_next  = s_tdata[28:19];
                            if (occ_reg >= CW'(CAPACITY)) begin
                                o_st_next = ST_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                wr_addr    = occ_reg[AW-1:0];
                                wr_data    = {s_tdata[18:3], s_tdata[28:19]};
                                occ_next   = occ_reg + 1'b1;
                                o_pos_next = occ_reg + 1'b1;
                            end
                            state_next = S_OUT;
                        end
                        MODE_DELETE, MODE_SEARCH: begin
                            o_key_next = s_tdata[18:3];
                            if (occ_reg == '0) begin
                                o_st_next  = (s_tdata[2:0] == MODE_DELETE) ?
                                             ST_EMPTY : ST_NOTFOUND;
                                state_next = S_OUT;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        MODE_SORT: begin
                            if (occ_reg == '0) begin
                                o_st_next  = ST_EMPTY;
                                state_next = S_OUT;
                            end else begin
                                i_next     = CW'(1);
                                state_next = S_SORT_RD;
                            end
                        end
                        MODE_DUMP: begin
                            if (occ_reg == '0) begin
                                o_st_next  = ST_EMPTY;
                                state_next = S_OUT;
                            end else begin
                                state_next = S_DUMP_RD;
                            end
                        end
                        default: state_next = S_OUT;
                    endcase
                end
            end
            // read entry i issued; wait for data
            S_SCAN: begin
                state_next = S_SCAN_WAIT;
            end
            S_SCAN_WAIT: begin
                if (rd_key == key_reg) begin
                    o_pos_next = i_reg + 1'b1;
                    o_key_next = rd_key;
                    o_sc_next  = rd_sc;
                    if (mode_reg == MODE_DELETE) begin
                        occ_next   = occ_reg - 1'b1;
                        i_next     = i_reg + 1'b1;
                        state_next = (i_reg + 1'b1 >= occ_reg) ? S_OUT : S_SHIFT_RD;
                    end else begin
                        state_next = S_OUT;
                    end
                end else if (i_reg + 1'b1 >= occ_reg) begin
                    o_st_next  = ST_NOTFOUND;
                    state_next = S_OUT;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end
            // close the gap: read entry i, write it to i-1
            S_SHIFT_RD: begin
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                wr_en   = 1'b1;
                wr_addr = AW'(i_reg - 1'b1);
                wr_data = rd_data;
                i_next  = i_reg + 1'b1;
                // occ_reg already decremented: last source index is occ_reg
                state_next = (i_reg >= occ_reg) ? S_OUT : S_SHIFT_RD;
            end
            // insertion sort: read record i to insert
            S_SORT_RD: begin
                if (i_reg >= occ_reg) begin
                    state_next = S_OUT;
                end else begin
                    rd_addr    = i_reg[AW-1:0];
                    j_next     = i_reg;
                    state_next = S_SORT_LOAD;
                end
            end
            // hold the record and probe its left neighbor
            S_SORT_LOAD: begin
                hold_next  = rd_data;
                rd_addr    = AW'(i_reg - 1'b1);
                state_next = S_SORT_CMP;
            end
            // data is entry j-1; strict compare keeps equal keys in order
            S_SORT_CMP: begin
                wr_en   = 1'b1;
                wr_addr = j_reg[AW-1:0];
                if (rd_key > hold_reg[REC_W-1:SCORE_W]) begin
                    wr_data = rd_data;
                    j_next  = j_reg - 1'b1;
                    if (j_reg == CW'(1)) begin
                        state_next = S_SORT_PUT;
                    end else begin
                        rd_addr    = AW'(j_reg - CW'(2));
                        state_next = S_SORT_CMP;
                    end
                end else begin
                    wr_data    = hold_reg;
                    i_next     = i_reg + 1'b1;
                    state_next = S_SORT_RD;
                end
            end
            // record goes to the front
            S_SORT_PUT: begin
                wr_en      = 1'b1;
                wr_addr    = j_reg[AW-1:0];
                wr_data    = hold_reg;
                i_next     = i_reg + 1'b1;
                state_next = S_SORT_RD;
            end
            S_DUMP_RD: begin
                state_next = S_DUMP_OUT;
            end
            S_DUMP_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    i_next     = i_reg + 1'b1;
                    rd_addr    = AW'(i_reg + 1'b1);
                    state_next = (i_reg + 1'b1 >= occ_reg) ? S_IDLE : S_DUMP_OUT;
                end else begin
                    rd_addr = i_reg[AW-1:0];
                end
            end
            S_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // result fields: dump records come straight from the memory read register
    always_comb begin
        if (state_reg == S_DUMP_OUT) begin
            m_tdata = {6'(occ_reg), rd_sc, rd_key, 6'(i_reg + 1'b1), ST_OK};
            m_tlast = (i_reg + 1'b1 == occ_reg);
        end else begin
            m_tdata = {6'(occ_reg), o_sc_reg, o_key_reg, 6'(o_pos_reg), o_st_reg};
            m_tlast = o_last_reg;
        end
    end

endmodule
